// ===== hw/rtl/cbrp_pkg.sv =====
// Shared constants and types for the CSV blob record parser.
// No dependencies; compiled first.
package cbrp_pkg;

  // Character codes recognised by the parser
  localparam logic [7:0] LINE_END  = 8'h0A;
  localparam logic [7:0] FIELD_SEP = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Result field width and commas needed for a well formed line
  localparam int unsigned OUT_WIDTH    = 16;
  localparam int unsigned LINE_FIELDS  = 4;

  // Registered byte handed from the input stage to the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } cbrp_byte_t;

endpackage

// ===== hw/rtl/cbrp_rx_if.sv =====
// Byte channel into the parser: valid, ready and one received byte.
// No dependencies.
interface cbrp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/cbrp_blob_if.sv =====
// Result channel out of the parser: found flags and the held blob.
// Depends on cbrp_pkg for the result field width.
interface cbrp_blob_if
  import cbrp_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic                        well_formed;
  logic signed [OUT_WIDTH-1:0] blob_x;
  logic signed [OUT_WIDTH-1:0] blob_y;
  logic signed [OUT_WIDTH-1:0] blob_width;
  logic signed [OUT_WIDTH-1:0] blob_height;
  logic signed [OUT_WIDTH-1:0] blob_signature;

  modport source (output valid, output found, output well_formed, output blob_x,
                  output blob_y, output blob_width, output blob_height,
                  output blob_signature, input ready);
  modport sink   (input valid, input found, input well_formed, input blob_x,
                  input blob_y, input blob_width, input blob_height,
                  input blob_signature, output ready);
endinterface

// ===== hw/rtl/cbrp_in_stage.sv =====
// Input register for the parser: takes one byte per transfer.
// Depends on cbrp_pkg and cbrp_rx_if.
module cbrp_in_stage
  import cbrp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  cbrp_rx_if.sink    rx,
  input  logic       take_i,
  output cbrp_byte_t byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  // Accept whenever the register is empty or is being consumed this cycle
  assign rx.ready = !valid_q || take_i;

  // Hold valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rx.ready) begin
      valid_q <= rx.valid;
    end
  end

  // Capture payload on transfer
  always_ff @(posedge clk_i) begin
    if (rx.valid && rx.ready) begin
      byte_q <= rx.rx_byte;
    end
  end

  assign byte_o.valid   = valid_q;
  assign byte_o.rx_byte = byte_q;

endmodule

// ===== hw/rtl/cbrp_field_parser.sv =====
// Field parser: converts bytes to line fields, keeps the held blob and
// drives the result register. Depends on cbrp_pkg and cbrp_blob_if.
module cbrp_field_parser
  import cbrp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cbrp_byte_t byte_i,
  output logic       take_o,
  cbrp_blob_if.source blob
);

  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_STOP   = 2'd2
  } phase_e;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  phase_e     phase_q, phase_d;
  logic       neg_q, neg_d;
  value_t     acc_q, acc_d;
  logic [2:0] fidx_q, fidx_d;
  value_t     line_q [LINE_FIELDS];
  value_t     held_q [LINE_FIELDS];
  value_t     sig_q;
  logic       found_q;
  logic       formed_q;
  logic       out_valid_q, out_valid_d;

  logic       is_end;
  logic       is_sep;
  logic       is_digit;
  logic       is_space;
  logic       formed;
  logic       slot_free;
  value_t     field_val;
  value_t     digit_val;
  value_t     acc_x10;

  // Decode the byte
  always_comb begin
    is_end    = (byte_i.rx_byte == LINE_END);
    is_sep    = (byte_i.rx_byte == FIELD_SEP) && !fidx_q[2];
    is_digit  = byte_i.rx_byte inside {[CH_ZERO:CH_NINE]};
    is_space  = (byte_i.rx_byte == CH_SPACE) ||
                (byte_i.rx_byte inside {[CH_TAB:CH_CR]});
    digit_val = value_t'(byte_i.rx_byte[3:0]);
    acc_x10   = (acc_q <<< 3) + (acc_q <<< 1);
    field_val = neg_q ? -acc_q : acc_q;
    formed    = fidx_q[2];
  end

  // Consume a byte unless it ends a line while the result is still waiting
  assign slot_free = !out_valid_q || blob.ready;
  assign take_o    = byte_i.valid && (!is_end || slot_free);

  // Raise the result on a closed line, drop it once transferred
  assign out_valid_d = (take_o && is_end) ? 1'b1 : (blob.ready ? 1'b0 : out_valid_q);

  // Next state of the current field
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    fidx_d  = fidx_q;
    if (is_end || is_sep) begin
      phase_d = PH_SPACE;
      neg_d   = 1'b0;
      acc_d   = '0;
      fidx_d  = is_end ? 3'd0 : fidx_q + 3'd1;
    end else begin
      case (phase_q)
        PH_SPACE: begin
          if (is_space) begin
            phase_d = PH_SPACE;
          end else if (byte_i.rx_byte inside {CH_PLUS, CH_MINUS}) begin
            neg_d   = (byte_i.rx_byte == CH_MINUS);
            phase_d = PH_DIGITS;
          end else if (is_digit) begin
            acc_d   = digit_val;
            phase_d = PH_DIGITS;
          end else begin
            phase_d = PH_STOP;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            acc_d = acc_x10 + digit_val;
          end else begin
            phase_d = PH_STOP;
          end
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  // Advance field state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SPACE;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      fidx_q      <= '0;
      found_q     <= 1'b0;
      formed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      sig_q       <= '0;
      for (int i = 0; i < LINE_FIELDS; i++) begin
        line_q[i] <= '0;
        held_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
        fidx_q  <= fidx_d;
        if (is_sep) begin
          line_q[fidx_q[1:0]] <= field_val;
        end
        if (is_end) begin
          // Close the line: load the blob only for a good record
          formed_q    <= formed;
          found_q     <= formed && (field_val != '0);
          if (formed && (field_val != '0)) begin
            sig_q <= field_val;
            for (int i = 0; i < LINE_FIELDS; i++) begin
              held_q[i] <= line_q[i];
            end
          end
          for (int i = 0; i < LINE_FIELDS; i++) begin
            line_q[i] <= '0;
          end
        end
      end
    end
  end

  // Drive the result channel; the blob only changes when a line closes
  assign blob.valid          = out_valid_q;
  assign blob.found          = found_q;
  assign blob.well_formed    = formed_q;
  assign blob.blob_x         = OUT_WIDTH'(held_q[0]);
  assign blob.blob_y         = OUT_WIDTH'(held_q[1]);
  assign blob.blob_width     = OUT_WIDTH'(held_q[2]);
  assign blob.blob_height    = OUT_WIDTH'(held_q[3]);
  assign blob.blob_signature = OUT_WIDTH'(sig_q);

  // Found always implies a well formed line
  a_found_formed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!found_q || formed_q))
    else $error("found set on a malformed line");

  // Comma count saturates at four
  a_fidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fidx_q <= 3'd4)
    else $error("field index out of range");

  // A closed line restarts the comma count
  a_line_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && is_end) |=> (fidx_q == 3'd0 && out_valid_q))
    else $error("line end did not restart parsing");

  // Held signature stays put while a result is stalled
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !blob.ready) |=> ($stable(sig_q) && $stable(found_q)))
    else $error("result changed while stalled");

endmodule

// ===== hw/rtl/csv_blob_record_parser_core.sv =====
// CSV blob record parser, top level.
// Depends on cbrp_pkg, cbrp_rx_if, cbrp_blob_if, cbrp_in_stage, cbrp_field_parser.
//
// Usage: bytes from the camera link enter on rx_i, one per transfer. Each line
// holds x, y, width, height and signature as comma-separated decimal integers
// and ends in a line feed. Fields are converted as they arrive; no line is
// buffered. Each line feed produces one transfer on blob_o carrying found,
// well_formed and the held blob (updated only by a line with four or more
// commas and a nonzero signature).
// Path: a byte is registered in the input stage on transfer and the field
// parser consumes it from there; a line feed's result is registered in the
// result register and held on blob_o until taken.
// Throughput: one byte per cycle, except while a line feed waits on a stalled
// result; the multiply-by-ten and add in the field parser are combinational.
// Reset: asynchronous, active low; clears all field state, the held blob and
// found, and empties both registers.
// Stall: while a result waits on blob_o, ordinary bytes keep flowing; the next
// line feed waits in the input register and rx_i.ready drops behind it.
module csv_blob_record_parser_core
  import cbrp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cbrp_rx_if.sink     rx_i,
  cbrp_blob_if.source blob_o
);

  cbrp_byte_t byte_s;
  logic       take_s;

  cbrp_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx     (rx_i),
    .take_i (take_s),
    .byte_o (byte_s)
  );

  cbrp_field_parser #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_field_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_s),
    .take_o (take_s),
    .blob   (blob_o)
  );

endmodule
